>>> rtl/trpg_pkg.sv
package trpg_pkg;

   // longest padded pulse that may be played
   localparam int MAX_LEN = 4096;

   // field widths
   localparam int IDX_W      = 12;
   localparam int CNT_W      = 13;
   localparam int LVL_W      = 16;
   localparam int ADC_W      = 16;
   localparam int STAT_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // internal widths
   localparam int LEN_W      = 17;              // sums of five lengths, padded
   localparam int K_W        = IDX_W;           // offset inside a ramp
   localparam int MAG_W      = LVL_W;           // |peak - base|
   localparam int PROD_W     = K_W + MAG_W;     // offset times magnitude
   localparam int QUO_W      = MAG_W;           // quotient stays below the magnitude
   localparam int DIV_STAGES = QUO_W;           // one quotient bit per stage
   localparam int SUM_W      = LVL_W + 3;       // level plus or minus quotient
   localparam int SMP_W      = 12;              // signed sample width before shift
   localparam int ADC_SHIFT  = ADC_W - SMP_W;

   // padding granule
   localparam int PAD_MULT   = 8;

   // clamp limits
   localparam int CLAMP_HI_TRIG = 2046;
   localparam int CLAMP_HI      = 2047;
   localparam int CLAMP_LO_TRIG = -2047;
   localparam int CLAMP_LO      = -2048;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_LEN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_LEN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_LEN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_LEN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_POST_LEN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_LEVEL = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LEVEL = 3'd6;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_PAST_END = 2'd1;
   localparam logic [STAT_W-1:0] STAT_LEN_ERR  = 2'd2;

   // pulse segment of a sample
   localparam logic [1:0] REGION_BASE = 2'd0;
   localparam logic [1:0] REGION_RISE = 2'd1;
   localparam logic [1:0] REGION_PEAK = 2'd2;
   localparam logic [1:0] REGION_FALL = 2'd3;

   // side information that rides along the divider
   typedef struct packed {
      logic [1:0]        region;
      logic              neg;
      logic [STAT_W-1:0] status;
      logic              last;
   } trpg_tag_type;

   // one result item
   typedef struct packed {
      logic [ADC_W-1:0]  adc_word;
      logic              last_sample;
      logic [STAT_W-1:0] status;
   } trpg_result_type;

endpackage

>>> rtl/trpg_req_if.sv
interface trpg_req_if;
   logic                          valid;
   logic                          ready;
   logic [trpg_pkg::IDX_W-1:0]    sample_index;

   modport source (output valid, output sample_index, input ready);
   modport sink (input valid, input sample_index, output ready);
endinterface

>>> rtl/trpg_rsp_if.sv
interface trpg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [trpg_pkg::ADC_W-1:0]    adc_word;
   logic                          last_sample;
   logic [trpg_pkg::STAT_W-1:0]   status;

   modport source (output valid, output adc_word, output last_sample, output status,
                   input ready);
   modport sink (input valid, input adc_word, input last_sample, input status,
                 output ready);
endinterface

>>> rtl/trpg_divider.sv
module trpg_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [trpg_pkg::PROD_W-1:0]   in_num,
   input  logic [trpg_pkg::CNT_W-1:0]    in_den,
   input  trpg_pkg::trpg_tag_type        in_tag,
   output logic                          out_valid,
   output logic [trpg_pkg::QUO_W-1:0]    out_quo,
   output trpg_pkg::trpg_tag_type        out_tag
);

   localparam int NS    = trpg_pkg::DIV_STAGES;
   localparam int QW    = trpg_pkg::QUO_W;
   localparam int CW    = trpg_pkg::CNT_W;
   localparam int PW    = trpg_pkg::PROD_W;

   logic                         vld_ff  [0:NS];
   logic [CW-1:0]                rem_ff  [0:NS];
   logic [QW-1:0]                low_ff  [0:NS];
   logic [QW-1:0]                quo_ff  [0:NS];
   logic [CW-1:0]                den_ff  [0:NS];
   trpg_pkg::trpg_tag_type       tag_ff  [0:NS];

   logic                         vld_in  [0:NS];
   logic [CW-1:0]                rem_in  [0:NS];
   logic [QW-1:0]                low_in  [0:NS];
   logic [QW-1:0]                quo_in  [0:NS];
   logic [CW-1:0]                den_in  [0:NS];
   trpg_pkg::trpg_tag_type       tag_in  [0:NS];

   // load stage: the high part of the dividend is already below the divisor
   always_comb begin
      vld_in[0] = in_valid;
      rem_in[0] = CW'(in_num[PW-1:QW]);
      low_in[0] = in_num[QW-1:0];
      quo_in[0] = '0;
      den_in[0] = in_den;
      tag_in[0] = in_tag;
   end

   // restoring steps, one quotient bit per stage
   for (genvar j = 1; j <= NS; j++) begin : g_step
      logic [CW:0] trial;
      logic        ge;

      always_comb begin
         trial     = {rem_ff[j-1], low_ff[j-1][QW-1]};
         ge        = trial >= {1'b0, den_ff[j-1]};
         vld_in[j] = vld_ff[j-1];
         rem_in[j] = ge ? CW'(trial - {1'b0, den_ff[j-1]}) : trial[CW-1:0];
         low_in[j] = {low_ff[j-1][QW-2:0], 1'b0};
         quo_in[j] = {quo_ff[j-1][QW-2:0], ge};
         den_in[j] = den_ff[j-1];
         tag_in[j] = tag_ff[j-1];
      end
   end

   // stage registers
   for (genvar j = 0; j <= NS; j++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_in[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in[j];
            low_ff[j] <= low_in[j];
            quo_ff[j] <= quo_in[j];
            den_ff[j] <= den_in[j];
            tag_ff[j] <= tag_in[j];
         end
      end
   end

   assign out_valid = vld_ff[NS];
   assign out_quo   = quo_ff[NS];
   assign out_tag   = tag_ff[NS];

endmodule

>>> rtl/trapezoid_pulse_sample_generator_unit.sv
// Trapezoid pulse sample generator: one ADC word per sample index.
// Path from the accepting edge to rsp valid: input register, segment decode, multiply,
// divider load plus 16 stages of one quotient bit each, output register.
// Throughput: one item per cycle; a skid entry behind the output register keeps input open
// while one result waits, and input stalls only while the skid entry is full.
// Synchronous active-high reset clears the valid bits and the pulse registers to 0.
module trapezoid_pulse_sample_generator_unit (
   input  logic                               clock,
   input  logic                               reset,
   trpg_req_if.sink                           req_if,
   trpg_rsp_if.source                         rsp_if,
   input  logic                               csr_we,
   input  logic [trpg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [trpg_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int LW = trpg_pkg::LEN_W;
   localparam int CW = trpg_pkg::CNT_W;
   localparam int VW = trpg_pkg::LVL_W;
   localparam int SW = trpg_pkg::SUM_W;

   // configuration registers
   logic [CW-1:0] pre_len_ff, rise_len_ff, high_len_ff, fall_len_ff, post_len_ff;
   logic [VW-1:0] peak_level_ff, base_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_len_ff    <= '0;
         rise_len_ff   <= '0;
         high_len_ff   <= '0;
         fall_len_ff   <= '0;
         post_len_ff   <= '0;
         peak_level_ff <= '0;
         base_level_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            trpg_pkg::CSR_PRE_LEN:    pre_len_ff    <= csr_wdata[CW-1:0];
            trpg_pkg::CSR_RISE_LEN:   rise_len_ff   <= csr_wdata[CW-1:0];
            trpg_pkg::CSR_HIGH_LEN:   high_len_ff   <= csr_wdata[CW-1:0];
            trpg_pkg::CSR_FALL_LEN:   fall_len_ff   <= csr_wdata[CW-1:0];
            trpg_pkg::CSR_POST_LEN:   post_len_ff   <= csr_wdata[CW-1:0];
            trpg_pkg::CSR_PEAK_LEVEL: peak_level_ff <= csr_wdata[VW-1:0];
            trpg_pkg::CSR_BASE_LEVEL: base_level_ff <= csr_wdata[VW-1:0];
            default: ;
         endcase
      end
   end

   // segment edges, padded length and level difference, rebuilt every cycle
   logic [LW-1:0]             e0_in, e1_in, e2_in, e3_in, total_in, padded_in;
   logic                      len_err_in, neg_in;
   logic [VW:0]               diff_in;
   logic [trpg_pkg::MAG_W-1:0] mag_in;
   logic [LW-1:0]             e0_ff, e1_ff, e2_ff, e3_ff, padded_ff;
   logic                      len_err_ff, neg_ff;
   logic [trpg_pkg::MAG_W-1:0] mag_ff;

   always_comb begin
      e0_in      = LW'(pre_len_ff);
      e1_in      = e0_in + LW'(rise_len_ff);
      e2_in      = e1_in + LW'(high_len_ff);
      e3_in      = e2_in + LW'(fall_len_ff);
      total_in   = e3_in + LW'(post_len_ff);
      padded_in  = (total_in + LW'(trpg_pkg::PAD_MULT - 1)) & ~LW'(trpg_pkg::PAD_MULT - 1);
      len_err_in = padded_in > LW'(trpg_pkg::MAX_LEN);
      diff_in    = {peak_level_ff[VW-1], peak_level_ff} - {base_level_ff[VW-1], base_level_ff};
      neg_in     = diff_in[VW];
      mag_in     = neg_in ? trpg_pkg::MAG_W'(-diff_in) : diff_in[VW-1:0];
   end

   always_ff @(posedge clock) begin
      e0_ff      <= e0_in;
      e1_ff      <= e1_in;
      e2_ff      <= e2_in;
      e3_ff      <= e3_in;
      padded_ff  <= padded_in;
      len_err_ff <= len_err_in;
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
   end

   // pipeline advance, held only while the skid entry is occupied
   logic en;
   logic skid_vld_ff;
   assign en           = !skid_vld_ff;
   assign req_if.ready = en;

   // stage 1: input register
   logic                        s1_vld_in, s1_vld_ff;
   logic [trpg_pkg::IDX_W-1:0]  s1_idx_in, s1_idx_ff;

   assign s1_vld_in = req_if.valid;
   assign s1_idx_in = req_if.sample_index;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_idx_ff <= s1_idx_in;
      end
   end

   // stage 2: segment decode, ramp offset and divisor, status
   logic                        s2_vld_in, s2_vld_ff;
   logic [trpg_pkg::K_W-1:0]    s2_k_in, s2_k_ff;
   logic [CW-1:0]               s2_den_in, s2_den_ff;
   trpg_pkg::trpg_tag_type      s2_tag_in, s2_tag_ff;
   logic [LW-1:0]               idx_ext;

   always_comb begin
      idx_ext          = LW'(s1_idx_ff);
      s2_vld_in        = s1_vld_ff;
      s2_k_in          = '0;
      s2_den_in        = CW'(1);
      s2_tag_in.neg    = neg_ff;
      s2_tag_in.region = trpg_pkg::REGION_BASE;
      if (idx_ext < e0_ff) begin
         s2_tag_in.region = trpg_pkg::REGION_BASE;
      end else if (idx_ext < e1_ff) begin
         s2_tag_in.region = trpg_pkg::REGION_RISE;
         s2_k_in          = trpg_pkg::K_W'(idx_ext - e0_ff);
         s2_den_in        = rise_len_ff;
      end else if (idx_ext < e2_ff) begin
         s2_tag_in.region = trpg_pkg::REGION_PEAK;
      end else if (idx_ext < e3_ff) begin
         s2_tag_in.region = trpg_pkg::REGION_FALL;
         s2_k_in          = trpg_pkg::K_W'(idx_ext - e2_ff);
         s2_den_in        = fall_len_ff;
      end
      // too-long pulse wins over past-end
      if (len_err_ff) begin
         s2_tag_in.status = trpg_pkg::STAT_LEN_ERR;
      end else if (idx_ext >= padded_ff) begin
         s2_tag_in.status = trpg_pkg::STAT_PAST_END;
      end else begin
         s2_tag_in.status = trpg_pkg::STAT_OK;
      end
      s2_tag_in.last = idx_ext == (padded_ff - LW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_k_ff   <= s2_k_in;
         s2_den_ff <= s2_den_in;
         s2_tag_ff <= s2_tag_in;
      end
   end

   // stage 3: offset times level magnitude
   logic                        s3_vld_in, s3_vld_ff;
   logic [trpg_pkg::PROD_W-1:0] s3_prod_in, s3_prod_ff;
   logic [CW-1:0]               s3_den_ff;
   trpg_pkg::trpg_tag_type      s3_tag_ff;

   assign s3_vld_in  = s2_vld_ff;
   assign s3_prod_in = s2_k_ff * mag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s3_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_prod_ff <= s3_prod_in;
         s3_den_ff  <= s2_den_ff;
         s3_tag_ff  <= s2_tag_ff;
      end
   end

   // divider stages
   logic                        div_vld;
   logic [trpg_pkg::QUO_W-1:0]  div_quo;
   trpg_pkg::trpg_tag_type      div_tag;

   trpg_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_vld_ff),
      .in_num    (s3_prod_ff),
      .in_den    (s3_den_ff),
      .in_tag    (s3_tag_ff),
      .out_valid (div_vld),
      .out_quo   (div_quo),
      .out_tag   (div_tag)
   );

   // level select, ramp sum, clamp and word format
   logic signed [SW-1:0]        delta, base_ext, peak_ext, smp, clamped;
   trpg_pkg::trpg_result_type   result;

   always_comb begin
      base_ext = SW'(signed'(base_level_ff));
      peak_ext = SW'(signed'(peak_level_ff));
      delta    = div_tag.neg ? -signed'(SW'(div_quo)) : signed'(SW'(div_quo));
      case (div_tag.region)
         trpg_pkg::REGION_RISE: smp = base_ext + delta;
         trpg_pkg::REGION_PEAK: smp = peak_ext;
         trpg_pkg::REGION_FALL: smp = peak_ext - delta;
         default:               smp = base_ext;
      endcase
      if (smp > SW'(trpg_pkg::CLAMP_HI_TRIG)) begin
         clamped = SW'(trpg_pkg::CLAMP_HI);
      end else if (smp < SW'(trpg_pkg::CLAMP_LO_TRIG)) begin
         clamped = SW'(trpg_pkg::CLAMP_LO);
      end else begin
         clamped = smp;
      end
      result.status = div_tag.status;
      if (div_tag.status == trpg_pkg::STAT_OK) begin
         result.adc_word    = {clamped[trpg_pkg::SMP_W-1:0], trpg_pkg::ADC_SHIFT'(0)};
         result.last_sample = div_tag.last;
      end else begin
         result.adc_word    = '0;
         result.last_sample = 1'b0;
      end
   end

   // output register with one skid entry behind it
   logic                        incoming, rsp_take;
   logic                        out_vld_in, out_vld_ff, skid_vld_in;
   trpg_pkg::trpg_result_type   out_data_in, out_data_ff, skid_data_in, skid_data_ff;

   assign incoming = div_vld && en;
   assign rsp_take = out_vld_ff && rsp_if.ready;

   always_comb begin
      out_vld_in   = out_vld_ff;
      out_data_in  = out_data_ff;
      skid_vld_in  = skid_vld_ff;
      skid_data_in = skid_data_ff;
      if (skid_vld_ff) begin
         if (rsp_take) begin
            out_data_in = skid_data_ff;
            skid_vld_in = 1'b0;
         end
      end else if (incoming) begin
         if (!out_vld_ff || rsp_take) begin
            out_vld_in  = 1'b1;
            out_data_in = result;
         end else begin
            skid_vld_in  = 1'b1;
            skid_data_in = result;
         end
      end else if (rsp_take) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_if.valid       = out_vld_ff;
   assign rsp_if.adc_word    = out_data_ff.adc_word;
   assign rsp_if.last_sample = out_data_ff.last_sample;
   assign rsp_if.status      = out_data_ff.status;

endmodule

>>> tb/sv/trpg_sample_checker.sv
module trpg_sample_checker
   import trpg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   trpg_req_if                   req_mon,
   trpg_rsp_if                   rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow copy of the pulse registers
   logic        [CNT_W-1:0] pre_len, rise_len, high_len, fall_len, post_len;
   logic signed [LVL_W-1:0] peak_level, base_level;

   // samples still owed by the block, oldest first
   trpg_result_type sample_q[$];

   // expected sample for one index under the current pulse shape
   function automatic trpg_result_type trapezoid_sample(input logic [IDX_W-1:0] idx);
      trpg_result_type res;
      longint pos, end_pre, end_rise, end_high, end_fall, total_len, padded_len;
      longint peak, base, span, level;
      pos        = longint'(idx);
      end_pre    = longint'(pre_len);
      end_rise   = end_pre + longint'(rise_len);
      end_high   = end_rise + longint'(high_len);
      end_fall   = end_high + longint'(fall_len);
      total_len  = end_fall + longint'(post_len);
      padded_len = ((total_len + PAD_MULT - 1) / PAD_MULT) * PAD_MULT;
      peak       = longint'(peak_level);
      base       = longint'(base_level);
      span       = peak - base;
      res        = '0;
      if (padded_len > MAX_LEN) begin
         res.status = STAT_LEN_ERR;
      end else if (pos >= padded_len) begin
         res.status = STAT_PAST_END;
      end else begin
         // pick the segment; division truncates toward zero
         if (pos < end_pre)
            level = base;
         else if (pos < end_rise)
            level = base + ((pos - end_pre) * span) / longint'(rise_len);
         else if (pos < end_high)
            level = peak;
         else if (pos < end_fall)
            level = peak - ((pos - end_high) * span) / longint'(fall_len);
         else
            level = base;
         // clamp to 12-bit signed, then place in the upper bits of the word
         if (level > CLAMP_HI_TRIG)
            level = CLAMP_HI;
         else if (level < CLAMP_LO_TRIG)
            level = CLAMP_LO;
         res.adc_word    = ADC_W'(level << ADC_SHIFT);
         res.last_sample = (pos == padded_len - 1);
         res.status      = STAT_OK;
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch_edge
      trpg_result_type want, got;
      if (reset) begin
         pre_len       = '0;
         rise_len      = '0;
         high_len      = '0;
         fall_len      = '0;
         post_len      = '0;
         peak_level    = '0;
         base_level    = '0;
         fail_count    = 0;
         sample_q.delete();
      end else begin
         // new request: predict with the registers in force now
         if (req_mon.valid && req_mon.ready)
            sample_q.push_back(trapezoid_sample(req_mon.sample_index));

         // returned item: compare with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.adc_word    = rsp_mon.adc_word;
            got.last_sample = rsp_mon.last_sample;
            got.status      = rsp_mon.status;
            if (sample_q.size() == 0) begin
               $display("%0t checker: unexpected item adc_word %h last_sample %b status %0d",
                        $time, got.adc_word, got.last_sample, got.status);
               fail_count++;
            end else begin
               want = sample_q.pop_front();
               if (got.adc_word !== want.adc_word) begin
                  $display("%0t checker: adc_word expected %h actual %h",
                           $time, want.adc_word, got.adc_word);
                  fail_count++;
               end
               if (got.last_sample !== want.last_sample) begin
                  $display("%0t checker: last_sample expected %b actual %b",
                           $time, want.last_sample, got.last_sample);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $display("%0t checker: status expected %0d actual %0d",
                           $time, want.status, got.status);
                  fail_count++;
               end
            end
         end

         // register writes; unknown indexes fall through
         if (csr_we) begin
            case (csr_index)
               CSR_PRE_LEN:    pre_len    = csr_wdata[CNT_W-1:0];
               CSR_RISE_LEN:   rise_len   = csr_wdata[CNT_W-1:0];
               CSR_HIGH_LEN:   high_len   = csr_wdata[CNT_W-1:0];
               CSR_FALL_LEN:   fall_len   = csr_wdata[CNT_W-1:0];
               CSR_POST_LEN:   post_len   = csr_wdata[CNT_W-1:0];
               CSR_PEAK_LEVEL: peak_level = csr_wdata[LVL_W-1:0];
               CSR_BASE_LEVEL: base_level = csr_wdata[LVL_W-1:0];
               default: ;
            endcase
         end
      end
      pending_count = sample_q.size();
   end

endmodule

>>> tb/sv/trapezoid_pulse_sample_generator_unit_test.sv
module trapezoid_pulse_sample_generator_unit_test
   import trpg_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                   CLOCK_PERIOD    = 10;
   localparam int                   RESET_CYCLES    = 7;
   localparam int                   QUIET_LIMIT     = 2000;
   localparam int                   HOLD_CYCLES     = 200;
   localparam int                   SETTLE_CYCLES   = 40;
   localparam int                   RANDOM_PHASES   = 10;
   localparam int                   ITEMS_PER_PHASE = 58;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE       = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending_count;
   int                    quiet_cycles = 0;
   int                    pulse_span;
   int                    steady_items = 0;
   logic                  hold_go = 1'b0;
   logic                  hold_done = 1'b0;

   trpg_req_if req_if ();
   trpg_rsp_if rsp_if ();

   trapezoid_pulse_sample_generator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   trpg_sample_checker sample_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // mostly short lengths so indexes land inside the pulse
   function automatic logic [CSR_DATA_W-1:0] random_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return CSR_DATA_W'($urandom_range(0, 24));
      if (r < 80) return CSR_DATA_W'($urandom_range(25, 400));
      if (r < 90) return CSR_DATA_W'($urandom_range(0, 1200));
      if (r < 93) return CSR_DATA_W'(0);
      if (r < 95) return CSR_DATA_W'(MAX_LEN);
      if (r < 97) return {CSR_DATA_W{1'b1}} >> (CSR_DATA_W - CNT_W);
      return CSR_DATA_W'($urandom_range(0, 65535));
   endfunction

   // levels around the clamp window, full range and extremes
   function automatic logic [CSR_DATA_W-1:0] random_level();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return CSR_DATA_W'($urandom_range(0, 6000) - 3000);
      if (r < 70) return CSR_DATA_W'($urandom_range(0, 65535));
      if (r < 78) return 16'h8000;
      if (r < 86) return 16'h7fff;
      return CSR_DATA_W'(CLAMP_HI_TRIG - 3 + $urandom_range(0, 6)) ^
             (($urandom_range(0, 1) == 1) ? 16'hffff : 16'h0000);
   endfunction

   // index mostly inside the padded pulse, some near its end and anywhere
   function automatic logic [IDX_W-1:0] pick_index(input int span);
      int r, v;
      r = $urandom_range(0, 99);
      if (span > 0 && span <= MAX_LEN && r < 65) return IDX_W'($urandom_range(0, span - 1));
      if (span > 0 && r < 80) begin
         v = span - 3 + $urandom_range(0, 5);
         if (v > MAX_LEN - 1) v = MAX_LEN - 1;
         if (v < 0) v = 0;
         return IDX_W'(v);
      end
      if (r < 92) return IDX_W'($urandom_range(0, MAX_LEN - 1));
      return r[0] ? IDX_W'(MAX_LEN - 1) : IDX_W'(0);
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // wait until every request has returned its item
   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // program the whole pulse shape and remember its padded length
   task automatic load_pulse(input logic [CSR_DATA_W-1:0] pre_v, rise_v, high_v, fall_v, post_v,
                             input logic [CSR_DATA_W-1:0] peak_v, base_v);
      int total;
      drain_results();
      write_csr(CSR_PRE_LEN, pre_v);
      write_csr(CSR_RISE_LEN, rise_v);
      write_csr(CSR_HIGH_LEN, high_v);
      write_csr(CSR_FALL_LEN, fall_v);
      write_csr(CSR_POST_LEN, post_v);
      write_csr(CSR_PEAK_LEVEL, peak_v);
      write_csr(CSR_BASE_LEVEL, base_v);
      total = int'(pre_v[CNT_W-1:0]) + int'(rise_v[CNT_W-1:0]) + int'(high_v[CNT_W-1:0]) +
              int'(fall_v[CNT_W-1:0]) + int'(post_v[CNT_W-1:0]);
      pulse_span = ((total + PAD_MULT - 1) / PAD_MULT) * PAD_MULT;
   endtask

   // offer one item after a random gap, hold it until taken
   task automatic send_index(input logic [IDX_W-1:0] idx);
      int gap;
      if (steady_items > 0) begin
         gap = 0;
         steady_items--;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 19) == 0) steady_items = $urandom_range(20, 40);
      end
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid        <= 1'b1;
      req_if.sample_index <= idx;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // result side back-pressure, with one long hold-off on request
   initial begin : rsp_stall
      int run_left, stall_left;
      run_left     = 0;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_done) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            if (run_left == 0 && stall_left == 0) begin
               run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
               stall_left = pick_gap();
            end
            if (run_left > 0) begin
               rsp_if.ready <= 1'b1;
               run_left--;
            end else begin
               rsp_if.ready <= 1'b0;
               stall_left--;
            end
         end
      end
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_if.valid        = 1'b0;
      req_if.sample_index = '0;
      pulse_span          = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty pulse after reset: everything is past the end
      send_index(IDX_W'(0));
      send_index(IDX_W'(MAX_LEN - 1));

      // small pulse: every segment, padding, last sample, past end
      load_pulse(16'd3, 16'd5, 16'd2, 16'd4, 16'd1, 16'd1000, -16'sd200);
      write_csr(CSR_SPARE, 16'd5);
      send_index(IDX_W'(0));
      send_index(IDX_W'(2));
      send_index(IDX_W'(3));
      send_index(IDX_W'(5));
      send_index(IDX_W'(7));
      send_index(IDX_W'(8));
      send_index(IDX_W'(9));
      send_index(IDX_W'(10));
      send_index(IDX_W'(13));
      send_index(IDX_W'(14));
      send_index(IDX_W'(15));
      send_index(IDX_W'(16));
      send_index(IDX_W'(MAX_LEN - 1));

      // full-length rise across the widest level span: clamps on both sides
      load_pulse(16'(MAX_LEN), 16'd0, 16'd0, 16'd0, 16'd0, 16'h7fff, 16'h8000);
      load_pulse(16'd0, 16'(MAX_LEN), 16'd0, 16'd0, 16'd0, 16'h7fff, 16'h8000);
      send_index(IDX_W'(0));
      send_index(IDX_W'(MAX_LEN / 2));
      send_index(IDX_W'(MAX_LEN - 1));

      // padded length over the maximum, also with the widest register value
      load_pulse(16'h1fff, 16'd0, 16'd0, 16'd0, 16'd0, 16'd100, 16'd0);
      send_index(IDX_W'(0));
      load_pulse(16'd4000, 16'd0, 16'd0, 16'd0, 16'd97, 16'd100, 16'd0);
      send_index(IDX_W'(MAX_LEN - 1));

      // random pulse shapes with mostly in-range indexes
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_pulse(random_length(), random_length(), random_length(), random_length(),
                    random_length(), random_level(), random_level());
         if ($urandom_range(0, 3) == 0) write_csr(CSR_SPARE, CSR_DATA_W'($urandom));
         if (phase == 1) hold_go = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_index(pick_index(pulse_span));
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
